>>> hw/rtl/lpd_pkg.sv
package lpd_pkg;

  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 32;

  localparam logic RegMaxPayload = 1'b0;

  localparam logic [CfgDataW-1:0] MaxPayloadRst = 32'd1048576;

  localparam logic [1:0] HdrB0 = 2'd0;
  localparam logic [1:0] HdrB1 = 2'd1;
  localparam logic [1:0] HdrB2 = 2'd2;

endpackage

>>> hw/rtl/lpd_cfg.sv
module lpd_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lpd_pkg::CfgAddrW-1:0]  paddr,
  input  logic [lpd_pkg::CfgDataW-1:0]  pwdata,
  output logic [lpd_pkg::CfgDataW-1:0]  prdata,
  output logic                          pready,
  output logic [lpd_pkg::CfgDataW-1:0]  max_payload_o
);
  import lpd_pkg::*;

  logic                sel_max;
  logic                wr_en;
  logic [CfgDataW-1:0] max_q;

  assign sel_max = (paddr[CfgAddrW-1] == RegMaxPayload);
  assign wr_en   = psel & penable & pwrite & sel_max;
  assign pready  = 1'b1;
  assign prdata  = sel_max ? max_q : '0;
  assign max_payload_o = max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= MaxPayloadRst;
    end else if (wr_en) begin
      max_q <= pwdata;
    end
  end

endmodule

>>> hw/rtl/length_prefixed_deframer_core.sv
// Length-prefixed deframer: one stream byte in, at most one result item out.
// Input channel: in_valid_i / in_ready_o with data_byte_i. Each frame is a
// 4-byte little-endian length followed by that many payload bytes.
// Output channel: out_valid_o / out_ready_i with payload_byte_o,
// frame_last_o, frame_empty_o and length_error_o. Header bytes give no item;
// a zero length gives one empty-frame item; a length above the configured
// maximum gives an error item, and every later byte an error item, until reset.
// Configuration: APB-style port, max_payload_bytes at address 0.
// Path: an accepted byte is registered in the input register, decoded from
// there, and its item is loaded into the output register once that is free.
// Throughput: one byte per cycle while the output is not stalled; the decode is
// two counters and the 32-bit compares between the input and output registers.
// Stall: the output register holds while out_ready_i is low; the input
// register then holds a byte that needs an item, and in_ready_o drops.
// Bytes that give no item pass through the input register regardless.
// Reset: clears the header count, payload count, sticky error and both
// valid flags, and restores the maximum to 1048576.
module length_prefixed_deframer_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    data_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [7:0]                    payload_byte_o,
  output logic                          frame_last_o,
  output logic                          frame_empty_o,
  output logic                          length_error_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lpd_pkg::CfgAddrW-1:0]  paddr,
  input  logic [lpd_pkg::CfgDataW-1:0]  pwdata,
  output logic [lpd_pkg::CfgDataW-1:0]  prdata,
  output logic                          pready
);
  import lpd_pkg::*;

  logic [CfgDataW-1:0] max_payload;

  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_adv;
  logic       in_acc;

  logic [1:0]  hdr_q, hdr_d;
  logic [23:0] accum_q, accum_d;
  logic [31:0] rem_q, rem_d;
  logic        in_pay_q, in_pay_d;
  logic        err_q, err_d;
  logic [31:0] len;

  logic       res_vld;
  logic [7:0] res_byte;
  logic       res_last;
  logic       res_empty;
  logic       res_err;

  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       out_last_q;
  logic       out_empty_q;
  logic       out_err_q;
  logic       out_free;

  lpd_cfg u_cfg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .max_payload_o (max_payload)
  );

  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_adv     = s1_valid_q && (!res_vld || out_free);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_acc     = in_valid_i && in_ready_o;
  assign len        = {s1_byte_q, accum_q};

  always_comb begin
    hdr_d     = hdr_q;
    accum_d   = accum_q;
    rem_d     = rem_q;
    in_pay_d  = in_pay_q;
    err_d     = err_q;
    res_vld   = 1'b0;
    res_byte  = 8'd0;
    res_last  = 1'b0;
    res_empty = 1'b0;
    res_err   = 1'b0;
    if (err_q) begin
      res_vld = 1'b1;
      res_err = 1'b1;
    end else if (in_pay_q) begin
      res_vld  = 1'b1;
      res_byte = s1_byte_q;
      rem_d    = rem_q - 32'd1;
      res_last = (rem_q == 32'd1);
      if (res_last) begin
        in_pay_d = 1'b0;
      end
    end else begin
      case (hdr_q)
        HdrB0: begin
          accum_d[7:0] = s1_byte_q;
          hdr_d        = hdr_q + 2'd1;
        end
        HdrB1: begin
          accum_d[15:8] = s1_byte_q;
          hdr_d         = hdr_q + 2'd1;
        end
        HdrB2: begin
          accum_d[23:16] = s1_byte_q;
          hdr_d          = hdr_q + 2'd1;
        end
        default: begin
          hdr_d   = HdrB0;
          accum_d = '0;
          if (len > max_payload) begin
            err_d   = 1'b1;
            res_vld = 1'b1;
            res_err = 1'b1;
          end else if (len == 32'd0) begin
            res_vld   = 1'b1;
            res_last  = 1'b1;
            res_empty = 1'b1;
          end else begin
            rem_d    = len;
            in_pay_d = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_byte_q <= data_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_q    <= HdrB0;
      accum_q  <= '0;
      rem_q    <= '0;
      in_pay_q <= 1'b0;
      err_q    <= 1'b0;
    end else if (s1_adv) begin
      hdr_q    <= hdr_d;
      accum_q  <= accum_d;
      rem_q    <= rem_d;
      in_pay_q <= in_pay_d;
      err_q    <= err_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && res_vld) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && res_vld) begin
      out_byte_q  <= res_byte;
      out_last_q  <= res_last;
      out_empty_q <= res_empty;
      out_err_q   <= res_err;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign payload_byte_o = out_byte_q;
  assign frame_last_o   = out_last_q;
  assign frame_empty_o  = out_empty_q;
  assign length_error_o = out_err_q;

  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q |=> err_q)
    else $error("sticky length error cleared");

  a_err_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && length_error_o |-> !frame_last_o && !frame_empty_o
                                      && payload_byte_o == 8'd0)
    else $error("error item carries frame flags or data");

  a_empty_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_empty_o |-> frame_last_o && payload_byte_o == 8'd0)
    else $error("empty-frame item malformed");

  a_payload_hdr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_pay_q |-> hdr_q == HdrB0 && rem_q != 32'd0)
    else $error("payload state with header bytes pending or no bytes left");

endmodule

>>> verif/deframe_checker.sv
`timescale 1ns / 100ps

module deframe_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  logic [7:0]                   data_byte_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  logic [7:0]                   payload_byte_i,
  input  logic                         frame_last_i,
  input  logic                         frame_empty_i,
  input  logic                         length_error_i,
  input  logic                         psel_i,
  input  logic                         penable_i,
  input  logic                         pwrite_i,
  input  logic [lpd_pkg::CfgAddrW-1:0] paddr_i,
  input  logic [lpd_pkg::CfgDataW-1:0] pwdata_i,
  input  logic [lpd_pkg::CfgDataW-1:0] prdata_i,
  input  logic                         pready_i,
  output int                           mismatches_o,
  output int                           pending_o
);
  import lpd_pkg::*;

  localparam logic [1:0] HdrB3 = 2'd3;

  typedef struct packed {
    logic [7:0] pbyte;
    logic       last;
    logic       empty;
    logic       err;
  } frame_item_t;

  frame_item_t       due_items_q[$];
  logic [CfgDataW-1:0] max_len;
  logic [1:0]        hdr_cnt;
  logic [31:0]       len_acc;
  logic [31:0]       remaining;
  logic              in_payload;
  logic              err_stuck;
  int                errs = 0;

  task automatic deframe_byte(input logic [7:0] b);
    frame_item_t item;
    item = '0;
    if (err_stuck) begin
      item.err = 1'b1;
      due_items_q.push_back(item);
    end else if (in_payload) begin
      remaining = remaining - 32'd1;
      item.pbyte = b;
      item.last = (remaining == 32'd0);
      if (item.last) in_payload = 1'b0;
      due_items_q.push_back(item);
    end else begin
      len_acc = len_acc | (32'(b) << (8 * hdr_cnt));
      if (hdr_cnt != HdrB3) begin
        hdr_cnt = hdr_cnt + 2'd1;
      end else begin
        hdr_cnt = HdrB0;
        if (len_acc > max_len) begin
          err_stuck = 1'b1;
          item.err = 1'b1;
          due_items_q.push_back(item);
        end else if (len_acc == 32'd0) begin
          item.last = 1'b1;
          item.empty = 1'b1;
          due_items_q.push_back(item);
        end else begin
          remaining = len_acc;
          in_payload = 1'b1;
        end
        len_acc = '0;
      end
    end
  endtask

  function automatic bit field_ok(input string name, input logic [31:0] want,
                                  input logic [31:0] got);
    if (want !== got) begin
      $display("%0t mismatch on %s: expected %0h, got %0h", $time, name, want, got);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    frame_item_t want;
    if (!rst_ni) begin
      due_items_q.delete();
      max_len = MaxPayloadRst;
      hdr_cnt = HdrB0;
      len_acc = '0;
      remaining = '0;
      in_payload = 1'b0;
      err_stuck = 1'b0;
      pending_o <= 0;
    end else begin
      if (psel_i && penable_i && pready_i) begin
        if (pwrite_i) begin
          if (paddr_i[CfgAddrW-1:2] == RegMaxPayload) max_len = pwdata_i;
        end else if (paddr_i[CfgAddrW-1:2] == RegMaxPayload) begin
          if (!field_ok("max_payload_bytes read", max_len, prdata_i)) errs++;
        end
      end
      if (out_valid_i && out_ready_i) begin
        if (due_items_q.size() == 0) begin
          $display("%0t unexpected item: byte %0h last %0b empty %0b error %0b", $time,
                   payload_byte_i, frame_last_i, frame_empty_i, length_error_i);
          errs++;
        end else begin
          want = due_items_q.pop_front();
          if (!field_ok("payload_byte", 32'(want.pbyte), 32'(payload_byte_i))) errs++;
          if (!field_ok("frame_last", 32'(want.last), 32'(frame_last_i))) errs++;
          if (!field_ok("frame_empty", 32'(want.empty), 32'(frame_empty_i))) errs++;
          if (!field_ok("length_error", 32'(want.err), 32'(length_error_i))) errs++;
        end
      end
      if (in_valid_i && in_ready_i) deframe_byte(data_byte_i);
      pending_o <= due_items_q.size();
    end
    mismatches_o <= errs;
  end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import lpd_pkg::*;

  localparam int CycleLimit = 400000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [7:0]          data_byte_i = 8'h00;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [7:0]          payload_byte_o;
  logic                frame_last_o;
  logic                frame_empty_o;
  logic                length_error_o;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [CfgAddrW-1:0] paddr = '0;
  logic [CfgDataW-1:0] pwdata = '0;
  logic [CfgDataW-1:0] prdata;
  logic                pready;

  int          mismatches;
  int          pending;
  int unsigned sent = 0;
  int unsigned snd_idle = 27;
  int unsigned rcv_idle = 51;
  int unsigned cycle_cnt = 0;

  length_prefixed_deframer_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .data_byte_i   (data_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .payload_byte_o(payload_byte_o),
    .frame_last_o  (frame_last_o),
    .frame_empty_o (frame_empty_o),
    .length_error_o(length_error_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  deframe_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .data_byte_i   (data_byte_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .payload_byte_i(payload_byte_o),
    .frame_last_i  (frame_last_o),
    .frame_empty_i (frame_empty_o),
    .length_error_i(length_error_o),
    .psel_i        (psel),
    .penable_i     (penable),
    .pwrite_i      (pwrite),
    .paddr_i       (paddr),
    .pwdata_i      (pwdata),
    .prdata_i      (prdata),
    .pready_i      (pready),
    .mismatches_o  (mismatches),
    .pending_o     (pending)
  );

  initial forever #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= rcv_idle);
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < snd_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    data_byte_i <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent++;
  endtask

  task automatic send_header(input logic [31:0] len);
    for (int i = 0; i < 4; i++) send_byte(len[8*i +: 8]);
  endtask

  task automatic send_frame(input int unsigned len);
    send_header(len);
    repeat (len) send_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic random_frames(input int unsigned budget, input int unsigned cap);
    int unsigned stop_at;
    int unsigned len;
    stop_at = sent + budget;
    while (sent < stop_at) begin
      if ($urandom_range(0, 9) == 0) len = $urandom_range(0, cap);
      else len = $urandom_range(0, (cap < 12) ? cap : 12);
      send_frame(len);
    end
  endtask

  // hold input until every item is out, then let the pipeline empty
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic reg_access(input logic wr, input logic [CfgAddrW-1:0] addr,
                            input logic [CfgDataW-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_max(input logic [CfgDataW-1:0] value);
    reg_access(1'b1, {RegMaxPayload, 2'b00}, value);
    reg_access(1'b0, {RegMaxPayload, 2'b00}, '0);
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    reg_access(1'b0, {RegMaxPayload, 2'b00}, '0);

    send_frame(0);
    send_header(32'd1);
    send_byte(8'hFF);
    send_header(32'd2);
    send_byte(8'h00);
    send_byte(8'h55);
    send_header(32'd3);
    send_byte(8'hAA);
    send_byte(8'h01);
    send_byte(8'hFE);

    random_frames(150, 40);

    // change the limit in the middle of a frame
    send_header(32'd6);
    repeat (3) send_byte(8'($urandom_range(0, 255)));
    settle();
    set_max(32'd0);
    repeat (3) send_byte(8'($urandom_range(0, 255)));
    repeat (10) send_frame(0);

    settle();
    set_max(32'd9);
    snd_idle = 51;
    rcv_idle = 27;
    send_frame(9);
    random_frames(140, 9);

    settle();
    set_max(32'hFFFF_FFFF);
    snd_idle = 0;
    rcv_idle = 0;
    send_frame(257);
    random_frames(70, 40);

    settle();
    reg_access(1'b1, {~RegMaxPayload, 2'b00}, 32'd0);
    reg_access(1'b0, {RegMaxPayload, 2'b00}, '0);
    send_frame(5);

    settle();
    set_max(32'h7FFF_FFFF);
    snd_idle = 27;
    rcv_idle = 51;
    send_frame(3);
    send_header(32'h8000_0000);
    repeat (20) send_byte(8'($urandom_range(0, 255)));

    settle();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
